// ----- hw/rtl/aabb_pair_contact_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// aabb pair contact tracker assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef AABB_PAIR_CONTACT_TRACKER_MACROS_SVH
`define AABB_PAIR_CONTACT_TRACKER_MACROS_SVH

// same-cycle implication
`define APCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/apct_pkg.sv -----
// ----------------------------------------------------------------------------
// apct_pkg
// Types and constants of the aabb pair contact tracker.
// ----------------------------------------------------------------------------
package apct_pkg;

	localparam int GP_W        = 6;
	localparam int GRP_W       = 3;
	localparam int SLOT_IN_W   = 10;
	localparam int COORD_W     = 16;
	localparam int SIZE_W      = 15;
	localparam int EV_W        = 3;
	localparam int MASK_W      = 64;
	localparam int GROUP_COUNT = 8;
	localparam int PAIR_SLOTS_DEF = 1024;

	// shared adder width: holds 2*|dx| - (wl+wr) and the slot remainder subtract
	localparam int ALU_W = 18;

	localparam int TDATA_IN_W  = 144;
	localparam int TUSER_IN_W  = 2;
	localparam int TDATA_OUT_W = 8;

	typedef enum logic [EV_W-1:0] {
		EV_NONE  = 3'd0,
		EV_ENTER = 3'd1,
		EV_STAY  = 3'd2,
		EV_EXIT  = 3'd3,
		EV_SKIP  = 3'd4
	} ev_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_XDIF,
		ST_XABS,
		ST_XSUM,
		ST_XCMP,
		ST_YDIF,
		ST_YABS,
		ST_YSUM,
		ST_YCMP,
		ST_DECIDE
	} st_t;

endpackage

// ----- hw/rtl/aabb_pair_contact_tracker.sv -----
// ----------------------------------------------------------------------------
// aabb_pair_contact_tracker
// Tracks enter/stay/exit contact of candidate box pairs, one touching bit per slot.
// ----------------------------------------------------------------------------
// Each input word is one candidate pair of boxes (Q11.4 centres and sizes);
// each one yields exactly one output word with the contact event and the
// overlap flag. One 18-bit add/subtract unit does all additions and
// subtractions under a small sequencer, with two multipliers for the slot
// fold: the pair slot is folded into the table range (reciprocal multiply,
// back multiply, subtract), the strict overlap test runs on x then y, the
// decide state updates the touching bit and loads the output register, and
// the idle state takes the next word, so a new word is taken only after the
// previous one is through; the update waits while the previous output word
// is still held. The input is ready again while the previous output word
// still waits. After reset the touching table is cleared one entry per
// cycle before the first word is taken; mask writes are taken at any time.
module aabb_pair_contact_tracker #(
	parameter int PAIR_SLOTS = apct_pkg::PAIR_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [apct_pkg::MASK_W-1:0]      cfg_wr_data,  // group_pair_mask
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// group_pair, pair_slot, left_x, left_y, left_w, left_h,
	// right_x, right_y, right_w, right_h, zero pad
	input  logic [apct_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
	// same_object, either_dead
	input  logic [apct_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// contact_event, overlapping, zero pad
	output logic [apct_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
	import apct_pkg::*;

	localparam int SLOT_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;

	// slot / PAIR_SLOTS as (slot * RECIP_M) >> RECIP_SH, exact for 10-bit slots
	localparam int RECIP_SH = 2 * SLOT_IN_W;
	localparam int RECIP_M  = ((1 << RECIP_SH) + PAIR_SLOTS - 1) / PAIR_SLOTS;
	localparam int RECIP_W  = SLOT_IN_W + RECIP_SH;

	// input field views
	logic [GP_W-1:0]      in_gp;
	logic [SLOT_IN_W-1:0] in_slot;
	logic [GRP_W-1:0]     in_row;
	logic [GRP_W-1:0]     in_col;
	logic                 in_enabled;

	// item registers
	logic [SLOT_IN_W-1:0] slot_sh_q;
	logic [3:0]           step_q;
	logic [SLOT_W-1:0]    rem_q;
	logic [COORD_W-1:0]   lx_q, ly_q, rx_q, ry_q;
	logic [SIZE_W-1:0]    lw_q, lh_q, rw_q, rh_q;
	logic                 skip_q;
	logic                 dead_q;
	logic [ALU_W-1:0]     acc_q;
	logic [ALU_W-1:0]     sum_q;
	logic                 ovx_q;
	logic                 ov_q;

	// control
	st_t                  state_q, state_nx;
	logic [SLOT_W-1:0]    clr_q;
	logic [MASK_W-1:0]    mask_q;
	logic                 out_free;
	logic                 accept;

	// shared adder
	logic [ALU_W-1:0]     alu_a, alu_b, alu_y;
	logic                 alu_sub;
	logic                 alu_neg;

	// slot fold products
	logic [RECIP_W-1:0]          recip_prod;
	logic [SLOT_IN_W+SLOT_W:0]   back_prod;

	// touching table
	logic                 tbl [PAIR_SLOTS];
	logic                 tbl_we;
	logic [SLOT_W-1:0]    tbl_addr;
	logic                 tbl_wd;
	logic                 rd_q;

	// output register
	logic                 out_valid_q;
	ev_t                  out_ev_q;
	logic                 out_ov_q;
	ev_t                  ev_nx;

	assign in_gp   = s_axis_tdata[5:0];
	assign in_slot = s_axis_tdata[15:6];
	assign in_row  = in_gp[5:3];
	assign in_col  = in_gp[2:0];

	// reversed or out-of-range group pairs count as disabled
	assign in_enabled = (in_row <= in_col) &&
	                    ({1'b0, in_row} < 4'(GROUP_COUNT)) &&
	                    ({1'b0, in_col} < 4'(GROUP_COUNT)) &&
	                    mask_q[in_gp];

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	assign alu_neg = alu_y[ALU_W-1];

	// quotient estimate, then quotient times slot count
	assign recip_prod = slot_sh_q * RECIP_W'(RECIP_M);
	assign back_prod  = acc_q[SLOT_IN_W-1:0] * (SLOT_IN_W+SLOT_W+1)'(PAIR_SLOTS);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == SLOT_W'(PAIR_SLOTS - 1)) state_nx = ST_IDLE;
			ST_IDLE:   if (s_axis_tvalid) state_nx = ST_MOD;
			ST_MOD:    if (step_q == 4'd0) state_nx = ST_XDIF;
			ST_XDIF:   state_nx = ST_XABS;
			ST_XABS:   state_nx = ST_XSUM;
			ST_XSUM:   state_nx = ST_XCMP;
			ST_XCMP:   state_nx = ST_YDIF;
			ST_YDIF:   state_nx = ST_YABS;
			ST_YABS:   state_nx = ST_YSUM;
			ST_YSUM:   state_nx = ST_YCMP;
			ST_YCMP:   state_nx = ST_DECIDE;
			ST_DECIDE: if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		alu_a         = '0;
		alu_b         = '0;
		alu_sub       = 1'b1;
		tbl_we        = 1'b0;
		tbl_addr      = rem_q;
		tbl_wd        = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				tbl_we   = 1'b1;
				tbl_addr = clr_q;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_MOD: begin
				// slot minus quotient times slot count
				alu_a = ALU_W'(slot_sh_q);
				alu_b = acc_q;
			end
			ST_XDIF, ST_YDIF: begin
				alu_a = (state_q == ST_XDIF) ? {{(ALU_W-COORD_W){lx_q[COORD_W-1]}}, lx_q}
				                            : {{(ALU_W-COORD_W){ly_q[COORD_W-1]}}, ly_q};
				alu_b = (state_q == ST_XDIF) ? {{(ALU_W-COORD_W){rx_q[COORD_W-1]}}, rx_q}
				                            : {{(ALU_W-COORD_W){ry_q[COORD_W-1]}}, ry_q};
			end
			ST_XABS, ST_YABS: begin
				alu_b = acc_q;
			end
			ST_XSUM, ST_YSUM: begin
				alu_sub = 1'b0;
				alu_a   = (state_q == ST_XSUM) ? ALU_W'(lw_q) : ALU_W'(lh_q);
				alu_b   = (state_q == ST_XSUM) ? ALU_W'(rw_q) : ALU_W'(rh_q);
			end
			ST_XCMP, ST_YCMP: begin
				alu_a = {acc_q[ALU_W-2:0], 1'b0};
				alu_b = sum_q;
			end
			ST_DECIDE: begin
				// new touching bit is overlap without a dead side
				tbl_we = out_free && !skip_q;
				tbl_wd = ov_q && !dead_q;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// event decode
	always_comb begin
		if (skip_q) begin
			ev_nx = EV_SKIP;
		end else if (ov_q) begin
			if (rd_q) ev_nx = dead_q ? EV_EXIT : EV_STAY;
			else      ev_nx = dead_q ? EV_NONE : EV_ENTER;
		end else begin
			ev_nx = rd_q ? EV_EXIT : EV_NONE;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) clr_q <= clr_q + SLOT_W'(1);
			if (cfg_wr_en) mask_q <= cfg_wr_data;
			if (state_q == ST_DECIDE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					slot_sh_q <= in_slot;
					step_q    <= 4'd2;
					rem_q     <= '0;
					lx_q      <= s_axis_tdata[31:16];
					ly_q      <= s_axis_tdata[47:32];
					lw_q      <= s_axis_tdata[62:48];
					lh_q      <= s_axis_tdata[77:63];
					rx_q      <= s_axis_tdata[93:78];
					ry_q      <= s_axis_tdata[109:94];
					rw_q      <= s_axis_tdata[124:110];
					rh_q      <= s_axis_tdata[139:125];
					skip_q    <= s_axis_tuser[0] || !in_enabled;
					dead_q    <= s_axis_tuser[1];
				end
			end
			ST_MOD: begin
				case (step_q)
					4'd2:    acc_q <= ALU_W'(recip_prod[RECIP_W-1:RECIP_SH]);
					4'd1:    acc_q <= ALU_W'(back_prod[SLOT_IN_W-1:0]);
					default: rem_q <= alu_y[SLOT_W-1:0];
				endcase
				step_q <= step_q - 4'd1;
			end
			ST_XDIF, ST_YDIF: acc_q <= alu_y;
			ST_XABS, ST_YABS: if (acc_q[ALU_W-1]) acc_q <= alu_y;
			ST_XSUM, ST_YSUM: sum_q <= alu_y;
			ST_XCMP: ovx_q <= alu_neg;
			ST_YCMP: ov_q  <= ovx_q && alu_neg;
			ST_DECIDE: begin
				if (out_free) begin
					out_ev_q <= ev_nx;
					out_ov_q <= ov_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// touching table, registered read
	always_ff @(posedge clk) begin
		if (tbl_we) tbl[tbl_addr] <= tbl_wd;
		rd_q <= tbl[rem_q];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_OUT_W-EV_W-1){1'b0}}, out_ov_q, out_ev_q};

`include "aabb_pair_contact_tracker_macros.svh"

	`APCT_ASSERT_NXT(a_accept_starts_mod, accept, state_q == ST_MOD, "accept did not start slot fold")
	`APCT_ASSERT_IMP(a_slot_in_range, state_q == ST_DECIDE, rem_q <= SLOT_W'(PAIR_SLOTS - 1), "slot fold out of range")
	`APCT_ASSERT_NXT(a_decide_loads_out, state_q == ST_DECIDE && out_free, out_valid_q && state_q == ST_IDLE, "decide did not load output")
	`APCT_ASSERT_IMP(a_touch_needs_overlap, out_valid_q && (out_ev_q == EV_ENTER || out_ev_q == EV_STAY), out_ov_q, "enter or stay without overlap")

endmodule
